// ===== rtl/nau_pkg.sv =====
// Shared constants, the job type and the exponential factor table of the activation unit.
package nau_pkg;

  localparam int ROW_MAX = 32;
  localparam int FILL_W  = $clog2(ROW_MAX + 1);
  localparam int ADDR_W  = $clog2(ROW_MAX);
  localparam int EXP_W   = 32;
  localparam int TOTAL_W = 40;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);

  localparam logic [1:0] MODE_SIGMOID = 2'd0;
  localparam logic [1:0] MODE_TANH    = 2'd1;
  localparam logic [1:0] MODE_SOFTMAX = 2'd2;
  localparam logic [1:0] MODE_UNDEF   = 2'd3;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
  localparam logic [20:0] ONE_Q20   = 21'h10_0000;
  localparam logic [14:0] Q15_MAX   = 15'h7fff;

  // 2^(2^-(k+1)) in Q1.30
  function automatic logic [30:0] root_factor(input logic [2:0] k);
    logic [30:0] f;
    case (k)
      3'd0:    f = 31'd1518500250;
      3'd1:    f = 31'd1276901417;
      3'd2:    f = 31'd1170923762;
      3'd3:    f = 31'd1121280436;
      3'd4:    f = 31'd1097253709;
      3'd5:    f = 31'd1085434108;
      3'd6:    f = 31'd1079572136;
      default: f = 31'd1076653033;
    endcase
    return f;
  endfunction

  typedef struct packed {
    logic [EXP_W-1:0]   num;
    logic [TOTAL_W-1:0] den;
    logic               neg;
    logic               last;
    logic               ovf;
    logic               zero;
  } job_t;

endpackage

// ===== rtl/nau_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module nau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/nau_front.sv =====
// Front end: accepts items, builds the exponential, keeps the softmax row and issues divide jobs.
module nau_front import nau_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic signed [15:0] pre_activation_i,
  input  logic               last_in_row_i,
  input  logic [1:0]         mode_i,
  output logic               full_o,
  output job_t               job_o,
  output logic               job_push_o,
  input  logic               job_full_i
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ARG      = 4'd1;
  localparam logic [3:0] S_FACT     = 4'd2;
  localparam logic [3:0] S_TERM     = 4'd3;
  localparam logic [3:0] S_MIX      = 4'd4;
  localparam logic [3:0] S_SCALE    = 4'd5;
  localparam logic [3:0] S_ISSUE    = 4'd6;
  localparam logic [3:0] S_DRAIN_RD = 4'd7;
  localparam logic [3:0] S_DRAIN_WR = 4'd8;

  logic [3:0]          state_q, state_d;
  logic signed [15:0]  x_q, x_d;
  logic                last_q, last_d;
  logic [1:0]          mode_q, mode_d;
  logic [33:0]         u_q, u_d;
  logic [2:0]          k_q, k_d;
  logic [32:0]         acc_q, acc_d;
  logic [21:0]         term_q, term_d;
  logic [EXP_W-1:0]    e_q, e_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic                ovf_q, ovf_d;
  logic [ADDR_W-1:0]   idx_q, idx_d;

  logic                ram_we, ram_re;
  logic [EXP_W-1:0]    ram_rdata;

  logic signed [17:0]  xe, ax, arg;
  logic signed [35:0]  y;
  logic [7:0]          f8;
  logic [61:0]         fprod;
  logic [49:0]         tprod;
  logic [52:0]         mprod;
  logic [5:0]          nb;
  logic [5:0]          s;
  logic [63:0]         v;
  logic [EXP_W-1:0]    ec;
  logic                idx_last;

  nau_ram #(.WIDTH(EXP_W), .DEPTH(ROW_MAX)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i (e_q),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    xe   = 18'(x_q);
    ax   = x_q[15] ? -xe : xe;
    case (mode_q)
      MODE_SIGMOID: arg = -xe;
      MODE_TANH:    arg = -(ax <<< 1);
      default:      arg = xe;
    endcase
    y     = arg * $signed({1'b0, LOG2E_Q16});
    f8    = u_q[27:20];
    fprod = 62'(acc_q[30:0]) * 62'(root_factor(k_q));
    tprod = 50'(u_q[19:0]) * 50'(LN2_Q30);
    mprod = 53'(acc_q[30:0]) * 53'(term_q);
    nb    = u_q[33:28];
    s     = 6'd42 - nb;
    if (nb < 6'd42) begin
      v = (64'(acc_q) + (64'd1 << (s - 6'd1))) >> s;
    end else begin
      v = 64'(acc_q) << (nb - 6'd42);
    end
    ec       = (e_q > 32'(ONE_Q20)) ? 32'(ONE_Q20) : e_q;
    idx_last = (FILL_W'(idx_q) + FILL_W'(1)) == fill_q;
  end

  always_comb begin
    state_d    = state_q;
    x_d        = x_q;
    last_d     = last_q;
    mode_d     = mode_q;
    u_d        = u_q;
    k_d        = k_q;
    acc_d      = acc_q;
    term_d     = term_q;
    e_d        = e_q;
    fill_d     = fill_q;
    total_d    = total_q;
    ovf_d      = ovf_q;
    idx_d      = idx_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    job_push_o = 1'b0;
    job_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (push_i) begin
          x_d     = pre_activation_i;
          last_d  = last_in_row_i;
          mode_d  = mode_i;
          state_d = (mode_i == MODE_UNDEF) ? S_ISSUE : S_ARG;
        end
      end
      S_ARG: begin
        u_d     = y[33:0] + (34'd1 << 33);
        acc_d   = 33'(ONE_Q30);
        k_d     = 3'd0;
        state_d = S_FACT;
      end
      S_FACT: begin
        if (f8[3'd7 - k_q]) begin
          acc_d = 33'((fprod + (62'd1 << 29)) >> 30);
        end
        k_d = k_q + 3'd1;
        if (k_q == 3'd7) begin
          state_d = S_TERM;
        end
      end
      S_TERM: begin
        term_d  = tprod[49:28];
        state_d = S_MIX;
      end
      S_MIX: begin
        acc_d   = acc_q + 33'((mprod + 53'(1 << 29)) >> 30);
        state_d = S_SCALE;
      end
      S_SCALE: begin
        e_d     = (v[63:32] != '0) ? '1 : v[31:0];
        state_d = S_ISSUE;
      end
      S_ISSUE: begin
        case (mode_q)
          MODE_SOFTMAX: begin
            if (fill_q < FILL_W'(ROW_MAX)) begin
              ram_we  = 1'b1;
              fill_d  = fill_q + FILL_W'(1);
              total_d = total_q + TOTAL_W'(e_q);
            end else begin
              ovf_d = 1'b1;
            end
            idx_d   = '0;
            state_d = last_q ? S_DRAIN_RD : S_IDLE;
          end
          default: begin
            job_o.last = 1'b1;
            if (mode_q == MODE_SIGMOID) begin
              job_o.num = 32'(ONE_Q20);
              job_o.den = TOTAL_W'(ONE_Q20) + TOTAL_W'(e_q);
            end else if (mode_q == MODE_TANH) begin
              job_o.num = 32'(ONE_Q20) - ec;
              job_o.den = TOTAL_W'(ONE_Q20) + TOTAL_W'(ec);
              job_o.neg = x_q[15];
            end else begin
              job_o.zero = 1'b1;
            end
            if (!job_full_i) begin
              job_push_o = 1'b1;
              state_d    = S_IDLE;
            end
          end
        endcase
      end
      S_DRAIN_RD: begin
        ram_re  = 1'b1;
        state_d = S_DRAIN_WR;
      end
      S_DRAIN_WR: begin
        job_o.num  = ram_rdata;
        job_o.den  = total_q;
        job_o.last = idx_last;
        job_o.ovf  = ovf_q;
        job_o.zero = (total_q == '0);
        if (!job_full_i) begin
          job_push_o = 1'b1;
          if (idx_last) begin
            fill_d  = '0;
            total_d = '0;
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + ADDR_W'(1);
            state_d = S_DRAIN_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      total_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    last_q <= last_d;
    mode_q <= mode_d;
    u_q    <= u_d;
    k_q    <= k_d;
    acc_q  <= acc_d;
    term_q <= term_d;
    e_q    <= e_d;
    idx_q  <= idx_d;
  end

  assign full_o = (state_q != S_IDLE);

endmodule

// ===== rtl/nau_queue.sv =====
// Small job queue between the front end and the divider.
module nau_queue import nau_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  job_t            mem_q [QDEPTH];
  logic [QPTR_W:0] wptr_q, rptr_q;

  assign empty_o = (wptr_q == rptr_q);
  assign full_o  = (wptr_q[QPTR_W] != rptr_q[QPTR_W]) &&
                   (wptr_q[QPTR_W-1:0] == rptr_q[QPTR_W-1:0]);
  assign data_o  = mem_q[rptr_q[QPTR_W-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wptr_q <= wptr_q + (QPTR_W+1)'(1);
      end
      if (pop_i && !empty_o) begin
        rptr_q <= rptr_q + (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wptr_q[QPTR_W-1:0]] <= data_i;
    end
  end

endmodule

// ===== rtl/nau_back.sv =====
// Back end: restoring divider with saturation and the result output register.
module nau_back import nau_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  job_t               job_i,
  input  logic               job_empty_i,
  output logic               job_pop_o,
  output logic signed [15:0] activation_o,
  output logic               last_of_run_o,
  output logic               row_overflow_o,
  output logic               empty_o,
  input  logic               pop_i
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_SAT  = 2'd1;
  localparam logic [1:0] B_DIV  = 2'd2;
  localparam logic [1:0] B_DONE = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [48:0] rem_q, rem_d;
  logic [55:0] dsh_q, dsh_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [14:0] quo_q, quo_d;
  logic        neg_q, neg_d, last_q, last_d, ovf_q, ovf_d;
  logic        ovalid_q, ovalid_d;
  logic [15:0] act_q, act_d;
  logic        olast_q, olast_d, oovf_q, oovf_d;
  logic        ge;
  logic [15:0] mag;

  assign ge  = 56'(rem_q) >= dsh_q;
  assign mag = {1'b0, quo_q};

  always_comb begin
    state_d   = state_q;
    rem_d     = rem_q;
    dsh_d     = dsh_q;
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    neg_d     = neg_q;
    last_d    = last_q;
    ovf_d     = ovf_q;
    ovalid_d  = ovalid_q;
    act_d     = act_q;
    olast_d   = olast_q;
    oovf_d    = oovf_q;
    job_pop_o = 1'b0;
    if (pop_i && ovalid_q) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      B_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          neg_d     = job_i.neg;
          last_d    = job_i.last;
          ovf_d     = job_i.ovf;
          rem_d     = (49'(job_i.num) << 16) + 49'(job_i.den);
          dsh_d     = 56'(job_i.den) << 16;
          quo_d     = '0;
          if (job_i.zero || (job_i.den == '0)) begin
            state_d = B_DONE;
          end else begin
            state_d = B_SAT;
          end
        end
      end
      B_SAT: begin
        if (ge) begin
          quo_d   = Q15_MAX;
          state_d = B_DONE;
        end else begin
          dsh_d   = dsh_q >> 1;
          cnt_d   = 4'd14;
          state_d = B_DIV;
        end
      end
      B_DIV: begin
        if (ge) begin
          rem_d = rem_q - dsh_q[48:0];
        end
        quo_d = {quo_q[13:0], ge};
        dsh_d = dsh_q >> 1;
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (!ovalid_q || pop_i) begin
          ovalid_d = 1'b1;
          act_d    = neg_q ? -mag : mag;
          olast_d  = last_q;
          oovf_d   = ovf_q;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    dsh_q   <= dsh_d;
    cnt_q   <= cnt_d;
    quo_q   <= quo_d;
    neg_q   <= neg_d;
    last_q  <= last_d;
    ovf_q   <= ovf_d;
    act_q   <= act_d;
    olast_q <= olast_d;
    oovf_q  <= oovf_d;
  end

  assign empty_o        = !ovalid_q;
  assign activation_o   = act_q;
  assign last_of_run_o  = olast_q;
  assign row_overflow_o = oovf_q;

endmodule

// ===== rtl/neuron_activation_unit_core.sv =====
// Top level of the neuron activation unit: mode register, front end, job queue, divider.
//
// Takes signed Q4.12 values and gives signed Q1.15 results: sigmoid, tanh, or
// row-wise softmax (mode 2), selected by activation_mode; mode 3 gives zero
// results. Both sides are queues: push an item while full is low, pop a result
// while empty is low. The front end works on one item at a time; it builds e^x
// with a shared sequencer (one argument multiply, eight table-factor steps, two
// steps for the linear remainder, one scaling shift) and then issues a divide
// job. Each result then passes a restoring divider (setup, saturation check, 15
// quotient bits) and then the output register, with the 4-entry job queue
// letting the exponential of the next item overlap the current division. In
// softmax mode an item that does not close the row makes no result; the closing
// item replays the buffered row from the exponential RAM, one element at a time,
// through the divider. Rows longer than ROW_MAX keep their first ROW_MAX elements
// and flag row_overflow_o on every result of that row. Write activation_mode
// only when the unit is idle.
module neuron_activation_unit_core import nau_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               activation_mode_we_i,
  input  logic [1:0]         activation_mode_i,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] pre_activation_i,
  input  logic               last_in_row_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] activation_o,
  output logic               last_of_run_o,
  output logic               row_overflow_o
);

  logic [1:0] mode_q;
  job_t       fe_job, q_job;
  logic       fe_push, q_full, q_empty, be_pop;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SIGMOID;
    end else if (activation_mode_we_i) begin
      mode_q <= activation_mode_i;
    end
  end

  nau_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .pre_activation_i (pre_activation_i),
    .last_in_row_i    (last_in_row_i),
    .mode_i           (mode_q),
    .full_o           (full),
    .job_o            (fe_job),
    .job_push_o       (fe_push),
    .job_full_i       (q_full)
  );

  // decouples exponential generation from division
  nau_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .data_i  (fe_job),
    .full_o  (q_full),
    .pop_i   (be_pop),
    .data_o  (q_job),
    .empty_o (q_empty)
  );

  nau_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (q_job),
    .job_empty_i    (q_empty),
    .job_pop_o      (be_pop),
    .activation_o   (activation_o),
    .last_of_run_o  (last_of_run_o),
    .row_overflow_o (row_overflow_o),
    .empty_o        (empty),
    .pop_i          (pop)
  );

endmodule

// ===== rtl/nau_checker.sv =====
// Port-level assertions for the activation unit, bound to the top level.
module nau_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic signed [15:0] activation_o,
  input logic               last_of_run_o,
  input logic               row_overflow_o
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(activation_o) && $stable(last_of_run_o)
                          && $stable(row_overflow_o)))
    else $error("stalled result changed");

  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (activation_o != 16'sh8000))
    else $error("activation outside saturated range");

  a_ovf_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && row_overflow_o) |-> !activation_o[15])
    else $error("softmax result negative");

endmodule

bind neuron_activation_unit_core nau_checker u_nau_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .activation_o   (activation_o),
  .last_of_run_o  (last_of_run_o),
  .row_overflow_o (row_overflow_o)
);

// ===== tb/neuron_activation_unit_core_tb.sv =====
// Self-checking testbench for the neuron activation unit: sigmoid, tanh, softmax rows and the unused mode code.
`timescale 1ns / 100ps

module neuron_activation_unit_core_tb;
  import nau_pkg::*;

  // Clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Block ports
  logic               activation_mode_we_i = 1'b0;
  logic [1:0]         activation_mode_i = MODE_SIGMOID;
  logic               push = 1'b0;
  logic               full;
  logic signed [15:0] pre_activation_i = '0;
  logic               last_in_row_i = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [15:0] activation_o;
  logic               last_of_run_o;
  logic               row_overflow_o;

  neuron_activation_unit_core u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .activation_mode_we_i(activation_mode_we_i),
    .activation_mode_i   (activation_mode_i),
    .push                (push),
    .full                (full),
    .pre_activation_i    (pre_activation_i),
    .last_in_row_i       (last_in_row_i),
    .empty               (empty),
    .pop                 (pop),
    .activation_o        (activation_o),
    .last_of_run_o       (last_of_run_o),
    .row_overflow_o      (row_overflow_o)
  );

  typedef struct {
    logic signed [15:0] value;
    logic               last;
  } sample_t;

  typedef struct {
    logic signed [15:0] act;
    logic               last;
    logic               ovf;
  } act_res_t;

  localparam longint unsigned ROOT_TBL [8] = '{
    64'd1518500250, 64'd1276901417, 64'd1170923762, 64'd1121280436,
    64'd1097253709, 64'd1085434108, 64'd1079572136, 64'd1076653033
  };
  localparam longint unsigned ONE20 = 64'd1048576;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 80;

  sample_t  pending_samples[$];
  act_res_t expected_acts[$];

  // Shadow of the unit state
  logic [1:0]  mode_shadow;
  logic [31:0] row_exps [ROW_MAX];
  logic [39:0] row_sum;
  int          row_count;
  logic        row_dropped;

  int  errors = 0;
  int  results_seen = 0;
  int  rows_closed = 0;
  int  ovf_rows = 0;
  int  cycles = 0;
  bit  accepted = 1'b0;
  bit  quiet = 1'b0;
  int  push_gap = 0;
  int  pop_gap = 0;

  // e^(a/4096) as unsigned Q12.20, table plus linear remainder
  function automatic logic [31:0] exp_fix(input int a);
    longint          y;
    longint unsigned u, frac, acc, r, term, val;
    int              n, s;
    if (a < -65536) a = -65536;
    if (a > 65535) a = 65535;
    y = longint'(a) * 94548;
    u = longint'(y + (longint'(1) << 33));
    n = int'(u >> 28) - 32;
    frac = u & ((64'd1 << 28) - 1);
    acc = 64'd1 << 30;
    for (int i = 0; i < 8; i++) begin
      if (frac[27-i]) acc = (acc * ROOT_TBL[i] + (64'd1 << 29)) >> 30;
    end
    r = frac & ((64'd1 << 20) - 1);
    term = (r * 64'd744261118) >> 28;
    acc += (acc * term + (64'd1 << 29)) >> 30;
    if (n < 10) begin
      s = 10 - n;
      val = (acc + (64'd1 << (s - 1))) >> s;
    end else begin
      val = acc << (n - 10);
    end
    if (val > 64'hFFFF_FFFF) val = 64'hFFFF_FFFF;
    return val[31:0];
  endfunction

  // round(num * 2^15 / den), saturated
  function automatic logic [15:0] q15_ratio(input longint unsigned num,
                                            input longint unsigned den);
    longint unsigned q;
    if (den == 0) return 16'd0;
    q = ((num << 16) + den) / (den << 1);
    return (q > 32767) ? 16'd32767 : q[15:0];
  endfunction

  // Works out the results caused by one accepted item
  task automatic predict_activation(input sample_t s);
    act_res_t        res;
    longint unsigned e;
    int              ax;
    logic [15:0]     mag;
    res.ovf = 1'b0;
    res.last = 1'b1;
    case (mode_shadow)
      MODE_SIGMOID: begin
        e = exp_fix(-int'(s.value));
        res.act = q15_ratio(ONE20, ONE20 + e);
        expected_acts.push_back(res);
      end
      MODE_TANH: begin
        ax = (s.value < 0) ? -int'(s.value) : int'(s.value);
        e = exp_fix(-2 * ax);
        if (e > ONE20) e = ONE20;
        mag = q15_ratio(ONE20 - e, ONE20 + e);
        res.act = (s.value < 0) ? -mag : mag;
        expected_acts.push_back(res);
      end
      MODE_SOFTMAX: begin
        e = exp_fix(int'(s.value));
        if (row_count < ROW_MAX) begin
          row_exps[row_count] = e[31:0];
          row_count++;
          row_sum = row_sum + e[39:0];
        end else begin
          row_dropped = 1'b1;
        end
        if (s.last) begin
          // closing item replays the whole buffered row
          for (int i = 0; i < row_count; i++) begin
            res.act = q15_ratio(row_exps[i], row_sum);
            res.last = (i + 1 == row_count);
            res.ovf = row_dropped;
            expected_acts.push_back(res);
          end
          rows_closed++;
          if (row_dropped) ovf_rows++;
          row_sum = '0;
          row_count = 0;
          row_dropped = 1'b0;
        end
      end
      default: begin
        res.act = '0;
        expected_acts.push_back(res);
      end
    endcase
  endtask

  // Monitor: sample at rising edge, predict on accept, check on pop
  always @(posedge clk_i) begin
    act_res_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("TEST FAILED");
      $finish;
    end
    accepted = 1'b0;
    if (rst_ni) begin
      if (activation_mode_we_i) mode_shadow = activation_mode_i;
      if (push && !full) begin
        predict_activation('{value: pre_activation_i, last: last_in_row_i});
        accepted = 1'b1;
      end
      if (pop && !empty) begin
        results_seen++;
        if (expected_acts.size() == 0) begin
          errors++;
          $display("%0t: unexpected result act=%0d last=%0b ovf=%0b", $time,
                   activation_o, last_of_run_o, row_overflow_o);
        end else begin
          want = expected_acts.pop_front();
          if (activation_o !== want.act || last_of_run_o !== want.last ||
              row_overflow_o !== want.ovf) begin
            errors++;
            $display("%0t: mismatch expected act=%0d last=%0b ovf=%0b, got act=%0d last=%0b ovf=%0b",
                     $time, want.act, want.last, want.ovf,
                     activation_o, last_of_run_o, row_overflow_o);
          end
        end
      end
    end
  end

  // Driver: inputs change on the falling edge; bursts of idle on both sides
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!push || accepted) begin
        if (push_gap > 0) begin
          push_gap--;
          push <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          push_gap = $urandom_range(1, 9) - 1;
          push <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          sample_t s;
          s = pending_samples.pop_front();
          pre_activation_i <= s.value;
          last_in_row_i <= s.last;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        pop_gap = $urandom_range(1, 9) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic queue_sample(input int v, input bit last);
    pending_samples.push_back('{value: 16'(v), last: last});
  endtask

  // wait until every item is in and every result is out, then settle
  task automatic drain_unit();
    while (pending_samples.size() != 0 || push || expected_acts.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic [1:0] m);
    @(negedge clk_i);
    activation_mode_we_i <= 1'b1;
    activation_mode_i <= m;
    @(negedge clk_i);
    activation_mode_we_i <= 1'b0;
  endtask

  function automatic int pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535) - 32768;
      1: return $urandom_range(0, 16383) - 8192;
      2: return $urandom_range(0, 2047) - 1024;
      default: return $urandom_range(0, 1) ? 32767 : -32768;
    endcase
  endfunction

  initial begin
    int total;
    int len;
    logic [1:0] m;
    mode_shadow = MODE_SIGMOID;
    row_sum = '0;
    row_count = 0;
    row_dropped = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes per mode, short rows, an unused selector
    set_mode(MODE_SIGMOID);
    queue_sample(-32768, 1); queue_sample(32767, 0); queue_sample(0, 1);
    queue_sample(-1, 0);
    drain_unit();
    set_mode(MODE_TANH);
    queue_sample(-32768, 0); queue_sample(32767, 1); queue_sample(0, 0);
    queue_sample(-1, 1);
    drain_unit();
    set_mode(MODE_SOFTMAX);
    queue_sample(5000, 1);                        // single-element row
    queue_sample(32767, 0); queue_sample(-32768, 0); queue_sample(0, 1);
    queue_sample(1234, 0); queue_sample(-777, 0); // row left open
    drain_unit();
    set_mode(MODE_UNDEF);
    queue_sample(4096, 1); queue_sample(-4096, 0);
    drain_unit();
    set_mode(MODE_SIGMOID);                       // open row survives this
    queue_sample(8191, 0);
    drain_unit();
    set_mode(MODE_SOFTMAX);
    queue_sample(-2000, 1);                       // closes the held row
    drain_unit();

    // Random phases; each one drains fully before the next mode write
    total = 0;
    while (total < 150) begin
      case ($urandom_range(0, 6))
        0: m = MODE_SIGMOID;
        1: m = MODE_TANH;
        2: m = MODE_UNDEF;
        default: m = MODE_SOFTMAX;
      endcase
      quiet = (total > 120);
      set_mode(m);
      for (int k = 0; k < 4; k++) begin
        if (m == MODE_SOFTMAX) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 36)
                                            : $urandom_range(1, 6);
          for (int j = 0; j < len; j++)
            queue_sample(pick_value(), j == len - 1);
          if ($urandom_range(0, 5) == 0) queue_sample(pick_value(), 0);
          total += len;
        end else begin
          queue_sample(pick_value(), $urandom_range(0, 1));
          total++;
        end
      end
      drain_unit();
    end
    set_mode(MODE_SOFTMAX);                       // close anything left open
    queue_sample(0, 1);
    drain_unit();

    $display("Covered all four mode codes, %0d results, %0d softmax rows (%0d overflowed).",
             results_seen, rows_closed, ovf_rows);
    if (errors == 0 && expected_acts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/nau_pkg.sv
rtl/nau_ram.sv
rtl/nau_front.sv
rtl/nau_queue.sv
rtl/nau_back.sv
rtl/neuron_activation_unit_core.sv
rtl/nau_checker.sv
tb/neuron_activation_unit_core_tb.sv
